@@ rtl/tlf_pkg.sv @@
// Shared types and constants for the text line folder.
// Holds character codes, default sizes, register map and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
package tlf_pkg;

  // Character codes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChBlank = 8'h20;

  // Default sizes
  localparam int LineMaxDef  = 32;
  localparam int TabWidthDef = 8;

  // Register map
  localparam int          AddrW       = 3;
  localparam int          DataW       = 32;
  localparam int          FoldW       = 6;
  localparam logic        RegFoldIdx  = 1'b0;
  localparam logic [5:0]  FoldReset   = 6'd10;

  // Control for one buffer cell
  typedef struct packed {
    logic shift;  // take the right neighbor's byte
    logic load;   // take the write byte
  } cell_ctl_t;

endpackage

@@ rtl/tlf_cell.sv @@
// One byte cell of the line buffer chain.
// Depends on tlf_pkg for the cell control struct.
`timescale 1ns / 1ps
module tlf_cell
  import tlf_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] load_data_i,
  input  logic [7:0] nbr_data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  // Shift toward the front, load on a write, else hold
  always_comb begin
    data_d = data_q;
    if (ctl_i.shift) begin
      data_d = nbr_data_i;
    end else if (ctl_i.load) begin
      data_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/text_line_folder.sv @@
// An ordinary character or a newline that completes no line leaves the block ready for the next character;
// a tab writes up to TabWidth blanks, one blank written per cycle.
// A completed line of n characters drains one item per cycle while the output is not stalled (n + 1 items with the
// newline) by shifting the cell chain toward cell 0; the next item is taken after that.
// Throughput is set by that single output stage and the one-blank-per-cycle tab fill.
// Reset: column 0, no pending output, fold column 10; buffer bytes are not cleared.
`timescale 1ns / 1ps
module text_line_folder
  import tlf_pkg::*;
#(
  parameter int LineMax  = LineMaxDef,
  parameter int TabWidth = TabWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_char_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             last_o
);

  localparam int CntW = $clog2(LineMax + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StTab  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   column_q, column_d;
  logic [CntW-1:0]   blank_q, blank_d;     // last blank index above 0, zero if none
  logic [CntW-1:0]   cnt_q, cnt_d;         // bytes still to drain
  logic [CntW-1:0]   col_after_q, col_after_d;
  logic [FoldW-1:0]  fold_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic [CntW-1:0]   fold_eff;
  logic [CntW-1:0]   pos1;
  logic [CntW-1:0]   blank_eff;
  logic [CntW-1:0]   brk;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic              shift_en;
  logic [7:0]        cell_data [LineMax];
  logic              tab_stop  [2**CntW];

  // Tab stop table
  for (genvar g = 0; g < 2**CntW; g++) begin : g_stop
    localparam int Rem = g % TabWidth;
    assign tab_stop[g] = (Rem == 0);
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= FoldReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegFoldIdx)) begin
      fold_q <= pwdata[FoldW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFoldIdx) ? {{(DataW-FoldW){1'b0}}, fold_q} : '0;

  // Saturate the fold column to 2..LineMax
  always_comb begin
    if (fold_q < FoldW'(2)) begin
      fold_eff = CntW'(2);
    end else if (int'(fold_q) > LineMax) begin
      fold_eff = CntW'(LineMax);
    end else begin
      fold_eff = CntW'(fold_q);
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pos1       = column_q + CntW'(1);

  // Break point for an ordinary character that fills the line
  always_comb begin
    blank_eff = blank_q;
    if ((in_char_i == ChBlank) && (column_q != '0)) begin
      blank_eff = column_q;
    end
    brk = (blank_eff == '0) ? pos1 : blank_eff + CntW'(1);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    column_d    = column_q;
    blank_d     = blank_q;
    cnt_d       = cnt_q;
    col_after_d = col_after_q;
    wr_en       = 1'b0;
    wr_data     = ChBlank;
    shift_en    = 1'b0;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_char_i == ChNl) begin
            if (column_q != '0) begin
              state_d     = StEmit;
              cnt_d       = column_q;
              col_after_d = '0;
              blank_d     = '0;
            end
          end else begin
            wr_en   = 1'b1;
            wr_data = (in_char_i == ChTab) ? ChBlank : in_char_i;
            if (pos1 >= fold_eff) begin
              state_d     = StEmit;
              blank_d     = '0;
              if (in_char_i == ChTab) begin
                cnt_d       = pos1;
                col_after_d = '0;
              end else begin
                cnt_d       = brk;
                col_after_d = pos1 - brk;
              end
            end else begin
              column_d = pos1;
              if (((in_char_i == ChTab) || (in_char_i == ChBlank)) && (column_q != '0)) begin
                blank_d = column_q;
              end
              if ((in_char_i == ChTab) && !tab_stop[pos1]) begin
                state_d = StTab;
              end
            end
          end
        end
      end
      StTab: begin
        // Write one blank per cycle up to the tab stop or the fold column
        wr_en   = 1'b1;
        wr_data = ChBlank;
        if (pos1 >= fold_eff) begin
          state_d     = StEmit;
          cnt_d       = pos1;
          col_after_d = '0;
          blank_d     = '0;
        end else begin
          column_d = pos1;
          if (column_q != '0) begin
            blank_d = column_q;
          end
          if (tab_stop[pos1]) begin
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        // Drain cell 0 one byte per cycle while the output is free, then the newline
        if (out_free) begin
          out_load = 1'b1;
          if (cnt_q != '0) begin
            shift_en   = 1'b1;
            out_char_d = cell_data[0];
            out_last_d = 1'b0;
            cnt_d      = cnt_q - CntW'(1);
          end else begin
            out_char_d = ChNl;
            out_last_d = 1'b1;
            column_d   = col_after_q;
            state_d    = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      column_q    <= '0;
      blank_q     <= '0;
      cnt_q       <= '0;
      col_after_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      column_q    <= column_d;
      blank_q     <= blank_d;
      cnt_q       <= cnt_d;
      col_after_q <= col_after_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  // Line buffer chain
  for (genvar i = 0; i < LineMax; i++) begin : g_cell
    cell_ctl_t  ctl;
    logic [7:0] nbr;

    // shift first, then load
    assign ctl = {shift_en, wr_en && (column_q == CntW'(i))};

    if (i == LineMax - 1) begin : g_end
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    tlf_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .load_data_i (wr_data),
      .nbr_data_i  (nbr),
      .data_o      (cell_data[i])
    );
  end

endmodule

@@ tb/text_line_folder_test.sv @@
// Self-checking testbench for text_line_folder: character stream in, folded lines out.
// Predicts every output byte from its own line buffer model; drives the APB fold register.
// Depends on tlf_pkg and the text_line_folder RTL.
`timescale 1ns / 1ps
module text_line_folder_test;
  import tlf_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 3 * TabWidthDef;
  localparam logic [AddrW-1:0] FoldAddr = AddrW'(4 * RegFoldIdx);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } folded_t;

  typedef enum int {RxOpen, RxJitter, RxAlternate, RxSparse} rx_mode_e;

  // DUT connections, all inputs known from time zero
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [7:0]       in_char_i = 8'h00;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [7:0]       out_char_o;
  logic             last_o;

  // Line buffer model and expected output bytes
  logic [7:0] line_buf [LineMaxDef];
  int         line_col = 0;
  int         fold_reg = int'(FoldReset);
  folded_t    folded_q [$];

  // Bookkeeping
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned chars_sent = 0;
  int unsigned bytes_seen = 0;
  int unsigned fold_writes = 0;
  int unsigned burst_left = 0;

  // Receiver pattern state
  rx_mode_e    rx_mode = RxOpen;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;

  text_line_folder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
               folded_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  // Queue the first n buffered bytes followed by a newline that closes the item
  task automatic queue_line(input int n);
    int i;
    for (i = 0; i < n && i < LineMaxDef; i++) begin
      folded_q.push_back('{ch: line_buf[i], last: 1'b0});
    end
    folded_q.push_back('{ch: ChNl, last: 1'b1});
  endtask

  // Advance the line model by one accepted character
  task automatic fold_char(input logic [7:0] c);
    int f;
    int pos;
    int p;
    int brk;
    int i;
    f = fold_reg;
    if (f < 2) f = 2;
    if (f > LineMaxDef) f = LineMaxDef;
    pos = line_col;
    if (pos >= LineMaxDef) pos = LineMaxDef - 1;
    if (c == ChTab) begin
      // pad with blanks to the next tab stop or the fold column
      line_buf[pos] = ChBlank;
      pos++;
      while (pos < f && (pos % TabWidthDef) != 0) begin
        line_buf[pos] = ChBlank;
        pos++;
      end
      if (pos < f) begin
        line_col = pos;
      end else begin
        line_col = 0;
        queue_line(pos);
      end
    end else if (c == ChNl) begin
      // empty lines produce nothing
      line_col = 0;
      if (pos != 0) queue_line(pos);
    end else begin
      line_buf[pos] = c;
      pos++;
      if (pos < f) begin
        line_col = pos;
      end else begin
        // break after the last blank beyond the first slot, else take the whole line
        p = pos - 1;
        while (p > 0 && line_buf[p] != ChBlank) p--;
        brk = (p == 0) ? pos : p + 1;
        queue_line(brk);
        for (i = 0; brk + i < pos; i++) line_buf[i] = line_buf[brk + i];
        line_col = pos - brk;
      end
    end
  endtask

  // Check each output byte against the oldest expectation
  always @(posedge clk_i) begin
    folded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_seen++;
      if (folded_q.size() == 0) begin
        report_mismatch("unexpected out_char", 0, int'(out_char_o));
      end else begin
        want = folded_q.pop_front();
        if (out_char_o !== want.ch) begin
          report_mismatch("out_char", int'(want.ch), int'(out_char_o));
        end
        if (last_o !== want.last) report_mismatch("last", int'(want.last), int'(last_o));
      end
    end
  end

  // Receiver: rotating stall patterns plus an on-demand long hold
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 150);
    end else begin
      rx_mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RxOpen: begin
          out_ready_i <= 1'b1;
        end
        RxJitter: begin
          out_ready_i <= ($urandom_range(0, 3) != 0);
        end
        RxAlternate: begin
          out_ready_i <= cycle_cnt[0];
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Hold valid for one character until accepted; valid stays high for the next one
  task automatic send_char(input logic [7:0] c);
    in_valid_i <= 1'b1;
    in_char_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
    fold_char(c);
  endtask

  task automatic idle_input(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic offer_char(input logic [7:0] c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 5));
    end
    burst_left--;
    send_char(c);
  endtask

  // Stop sending and wait until every expected byte has come out, then let a tab finish
  task automatic drain_output();
    idle_input(1);
    while (folded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Write the fold column over APB while idle, then read it back
  task automatic set_fold(input logic [FoldW-1:0] v);
    drain_output();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FoldAddr;
    pwdata <= DataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready !== 1'b1) report_mismatch("pready", 1, int'(pready));
    fold_reg = int'(v);
    fold_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DataW'(v)) report_mismatch("fold_column readback", int'(v), int'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly words, blanks and line breaks, with some arbitrary bytes
  function automatic logic [7:0] text_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 58) return 8'(8'h61 + $urandom_range(0, 25));
    if (roll < 75) return ChBlank;
    if (roll < 82) return ChTab;
    if (roll < 88) return ChNl;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Byte extremes, empty lines, tab stops, blank breaks and fold changes mid-line
  task automatic test_directed_cases();
    send_char(ChNl);
    send_char(ChTab);
    send_char(ChTab);
    set_fold(6'd4);
    send_text("a bc");
    set_fold(6'd2);
    send_char("x");
    set_fold(6'd4);
    send_text(" bcd");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("cd");
    set_fold(6'd10);
    send_text("abcdef");
    set_fold(6'd3);
    send_char(ChTab);
    set_fold(6'd0);
    send_text("pq");
    set_fold(6'd63);
    send_char("z");
    send_char(ChNl);
  endtask

  // Random text across a sweep of fold settings, out-of-range values included
  task automatic test_random_text();
    logic [FoldW-1:0] folds [8];
    int k;
    int n;
    folds = '{6'd2, 6'd32, 6'd1, 6'd7, 6'd33, 6'd63, 6'd16, 6'($urandom_range(0, 63))};
    for (k = 0; k < 8; k++) begin
      set_fold(folds[k]);
      for (n = 0; n < 31; n++) offer_char(text_char());
    end
  endtask

  // Hold the output for a long stretch while the input keeps coming, then pause to empty
  task automatic test_output_backpressure();
    int n;
    set_fold(6'd5);
    hold_req = 1'b1;
    for (n = 0; n < 48; n++) send_char(text_char());
    drain_output();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_text();
    test_output_backpressure();
    drain_output();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d characters under %0d fold column writes; checked %0d output bytes,",
             chars_sent, fold_writes, bytes_seen);
    $display("with a %0d-cycle output hold and random stalls on both sides.", HoldCycles);
    if (err_cnt == 0 && folded_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", err_cnt, folded_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tlf_pkg.sv
rtl/tlf_cell.sv
rtl/text_line_folder.sv
tb/text_line_folder_test.sv
